// ===== rtl/core/cookie_patch_stream_rewriter_core_macros.svh =====
// Assertion macros used by the cookie patch rewriter checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef COOKIE_PATCH_STREAM_REWRITER_CORE_MACROS_SVH
`define COOKIE_PATCH_STREAM_REWRITER_CORE_MACROS_SVH

// Same-cycle implication.
`define CPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cps_pkg.sv =====
// Package for the cookie patch stream rewriter: beat types, opcodes, cookie.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

  localparam int          TABLE_DEPTH_DEF = 256;
  localparam int          TABLE_W         = 32;
  localparam int          WIN_LEN         = 8;

  localparam logic [7:0]  OP_LOAD64 = 8'h21;
  localparam logic [7:0]  OP_LOAD32 = 8'h20;
  localparam logic [7:0]  FILL_BYTE = 8'h00;
  localparam logic [31:0] COOKIE    = 32'hBA5E1018;

  localparam logic CMD_STREAM = 1'b0;
  localparam logic CMD_TABLE  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last;
    logic [7:0]  table_index;
    logic [31:0] table_value;
  } cps_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       index_error;
  } cps_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/cps_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Read returns the old word on a same-address write. Uses cps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cps_ram #(
  parameter int  WIDTH = cps_pkg::TABLE_W,
  parameter int  DEPTH = cps_pkg::TABLE_DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/cookie_patch_stream_rewriter_core.sv =====
// Cookie patch stream rewriter: top level with window, flush buffer and result queue.
// Depends on cps_pkg and cps_ram.
//
// Usage:
//   in_*  : valid/ready beats. cmd CMD_TABLE writes one patch table word
//           (no result); cmd CMD_STREAM carries one stream byte, last marks
//           the end of a buffer.
//   out_* : valid/ready beats of rewritten bytes, in stream order.
// Throughput and order:
//   One input beat per cycle while in_ready is high. A stream byte pushes
//   out the byte eight places earlier into the registered result queue.
//   A beat with last loads the flush buffer and the block then emits the
//   held bytes plus the last one, one a cycle while the queue has room,
//   with in_ready low until the final beat has entered the result queue.
//   The table lookup is read ahead from the next window's index bytes,
//   so the match/rewrite itself does not wait on the table read.
// Reset: synchronous; window, counters, queue and flush state clear. The
//   patch table is not cleared: entries must be written before use.
// Stall: a two-beat result queue sits before out_*; in_ready drops only
//   when both places are full or a flush is running.
`timescale 1ns / 1ps
`default_nettype none

module cookie_patch_stream_rewriter_core #(
  parameter int TABLE_DEPTH = cps_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cps_pkg::cps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cps_pkg::cps_out_t out_data
);

  import cps_pkg::*;

  localparam int          AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
  localparam logic [3:0]  WIN_N   = 4'(WIN_LEN);

  logic [7:0]  win_r   [WIN_LEN];
  logic [7:0]  win_nxt [WIN_LEN];
  logic [3:0]  held_r, held_nxt;
  logic [3:0]  fresh_r, fresh_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  fl_r   [WIN_LEN+1];
  logic [7:0]  fl_nxt [WIN_LEN+1];
  logic [3:0]  fl_left_r, fl_left_nxt;
  logic        fl_err_r, fl_err_nxt;
  logic        flush_r, flush_nxt;

  cps_out_t    q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic        byp_hit_r, byp_hit_nxt;
  logic [31:0] byp_data_r;

  logic        in_acc, stream_acc, tbl_acc, pop, push;
  cps_out_t    push_d;
  logic [7:0]  b;
  logic [7:0]  w  [WIN_LEN+1];
  logic [7:0]  wr [WIN_LEN+1];
  logic [31:0] idx, word, raddr_full, waddr_full;
  logic        match, in_range, err_set;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_q;

  assign in_ready   = !flush_r && (cnt_r != 2'd2);
  assign in_acc     = in_valid && in_ready;
  assign stream_acc = in_acc && (in_data.cmd == CMD_STREAM);
  assign tbl_acc    = in_acc && (in_data.cmd == CMD_TABLE);
  assign out_valid  = (cnt_r != 2'd0);
  assign out_data   = q0_r;
  assign pop        = out_valid && out_ready;
  assign b          = in_data.data_byte;

  // window with the arriving byte placed after the held ones
  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      w[i] = (held_r == 4'(i)) ? b : win_r[i];
    end
    w[WIN_LEN] = b;
  end

  assign idx      = {win_r[4], win_r[3], win_r[2], win_r[1]};
  assign in_range = idx < DEPTH_W;
  assign word     = byp_hit_r ? byp_data_r : ram_q;
  assign match    = (held_r == WIN_N) && (fresh_r >= WIN_N) &&
                    (win_r[0] == OP_LOAD64) &&
                    (win_r[5] == COOKIE[7:0])   && (win_r[6] == COOKIE[15:8]) &&
                    (win_r[7] == COOKIE[23:16]) && (b == COOKIE[31:24]);
  assign err_set  = err_r || (match && !in_range);

  always_comb begin
    for (int i = 0; i <= WIN_LEN; i++) begin
      wr[i] = w[i];
    end
    if (match && in_range) begin
      wr[0] = OP_LOAD32;
      wr[1] = word[7:0];
      wr[2] = word[15:8];
      wr[3] = word[23:16];
      wr[4] = word[31:24];
      wr[5] = FILL_BYTE;
      wr[6] = FILL_BYTE;
      wr[7] = FILL_BYTE;
      wr[8] = FILL_BYTE;
    end
  end

  // window, flush and push control
  always_comb begin
    win_nxt     = win_r;
    held_nxt    = held_r;
    fresh_nxt   = fresh_r;
    err_nxt     = err_r;
    fl_nxt      = fl_r;
    fl_left_nxt = fl_left_r;
    fl_err_nxt  = fl_err_r;
    flush_nxt   = flush_r;
    push        = 1'b0;
    push_d      = '0;

    if (stream_acc) begin
      if (match) begin
        fresh_nxt = '0;
      end else if (fresh_r < WIN_N) begin
        fresh_nxt = fresh_r + 4'd1;
      end
      err_nxt = err_set;
      if (!in_data.last) begin
        if (held_r == WIN_N) begin
          push           = 1'b1;
          push_d.out_byte = wr[0];
          for (int i = 0; i < WIN_LEN; i++) begin
            win_nxt[i] = wr[i+1];
          end
        end else begin
          for (int i = 0; i < WIN_LEN; i++) begin
            win_nxt[i] = wr[i];
          end
          held_nxt = held_r + 4'd1;
        end
      end else begin
        fl_nxt      = wr;
        fl_left_nxt = held_r + 4'd1;
        fl_err_nxt  = err_set;
        flush_nxt   = 1'b1;
        for (int i = 0; i < WIN_LEN; i++) begin
          win_nxt[i] = '0;
        end
        held_nxt  = '0;
        fresh_nxt = '0;
        err_nxt   = 1'b0;
      end
    end else if (flush_r && (cnt_r != 2'd2)) begin
      push               = 1'b1;
      push_d.out_byte    = fl_r[0];
      push_d.out_last    = (fl_left_r == 4'd1);
      push_d.index_error = (fl_left_r == 4'd1) && fl_err_r;
      for (int i = 0; i < WIN_LEN; i++) begin
        fl_nxt[i] = fl_r[i+1];
      end
      fl_left_nxt = fl_left_r - 4'd1;
      if (fl_left_r == 4'd1) begin
        flush_nxt = 1'b0;
      end
    end
  end

  // two-beat result queue, head in q0
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q0_nxt = push_d;
        end else begin
          q1_nxt = push_d;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt  = q1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          q0_nxt = push_d;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = push_d;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // table read is issued from the next window's index bytes
  assign raddr_full  = {win_nxt[4], win_nxt[3], win_nxt[2], win_nxt[1]};
  assign waddr_full  = {24'd0, in_data.table_index};
  assign ram_raddr   = raddr_full[AW-1:0];
  assign ram_waddr   = waddr_full[AW-1:0];
  assign ram_we      = tbl_acc && (waddr_full < DEPTH_W);
  assign byp_hit_nxt = ram_we && (ram_waddr == ram_raddr);

  cps_ram #(
    .WIDTH (TABLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.table_value),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      held_r    <= '0;
      fresh_r   <= '0;
      err_r     <= 1'b0;
      fl_left_r <= '0;
      flush_r   <= 1'b0;
      cnt_r     <= '0;
      byp_hit_r <= 1'b0;
    end else begin
      win_r     <= win_nxt;
      held_r    <= held_nxt;
      fresh_r   <= fresh_nxt;
      err_r     <= err_nxt;
      fl_left_r <= fl_left_nxt;
      flush_r   <= flush_nxt;
      cnt_r     <= cnt_nxt;
      byp_hit_r <= byp_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fl_r       <= fl_nxt;
    fl_err_r   <= fl_err_nxt;
    q0_r       <= q0_nxt;
    q1_r       <= q1_nxt;
    byp_data_r <= in_data.table_value;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cps_checker.sv =====
// Port-level checks for the cookie patch rewriter, bound to the top level.
// Depends on cps_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "cookie_patch_stream_rewriter_core_macros.svh"

module cps_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input cps_pkg::cps_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input cps_pkg::cps_out_t out_data
);

  import cps_pkg::*;

  logic stall, last_acc, tbl_acc, err_beat;

  assign stall    = out_valid && !out_ready;
  assign last_acc = in_valid && in_ready && (in_data.cmd == CMD_STREAM) && in_data.last;
  assign tbl_acc  = in_valid && in_ready && (in_data.cmd == CMD_TABLE);
  assign err_beat = out_valid && out_data.index_error;

  `CPS_ASSERT_NOW(a_err_on_last, err_beat, out_data.out_last, "index_error off the last beat")

  `CPS_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(out_data), "stalled beat changed")

  `CPS_ASSERT_NEXT(a_flush_blocks, last_acc, !in_ready, "input taken during flush")

  `CPS_ASSERT_NEXT(a_table_silent, tbl_acc && !out_valid, !out_valid, "table write gave a beat")

endmodule

bind cookie_patch_stream_rewriter_core cps_checker u_cps_checker (.*);

`default_nettype wire
